>>> rtl/core/rbpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbpc_pkg
// Shared types, codes and reset values for the roller blind position
// controller.
// ----------------------------------------------------------------------------
package rbpc_pkg;

    // Default build widths
    localparam int COUNT_WIDTH_DEF       = 10;
    localparam int PULSE_TIMER_WIDTH_DEF = 10;

    // Field and register widths
    localparam int FUNC_W    = 2;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 3;
    localparam int REV_W     = 10;
    localparam int PULSE_W   = 10;
    localparam int POS_W     = 10;
    localparam int STALL_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Width for signed position math; holds any count difference
    localparam int CALC_W = 18;
    // Width for pulse length compares; covers the widest pulse timer
    localparam int PT_CMP_W = 16;

    // Register reset values
    localparam logic [PULSE_W-1:0] UNFOLD_MIN_RST = 10'd550;
    localparam logic [PULSE_W-1:0] FOLD_MIN_RST   = 10'd500;
    localparam logic [PULSE_W-1:0] PULSE_MAX_RST  = 10'd1000;
    localparam logic [POS_W-1:0]   EXTENDED_RST   = 10'd15;
    localparam logic [POS_W-1:0]   STOWED_RST     = 10'd0;
    localparam logic [STALL_W-1:0] STALL_TO_RST   = 16'd5000;

    // Request function codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_REED   = 2'd1,
        FUNC_FOLD   = 2'd2,
        FUNC_UNFOLD = 2'd3
    } func_t;

    // Motion mode
    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE   = 2'd0,
        MODE_MOVING = 2'd1,
        MODE_ERROR  = 2'd2
    } mode_t;

    // Position status
    typedef enum logic [STATUS_W-1:0] {
        ST_NONE     = 3'd0,
        ST_MOVING   = 3'd1,
        ST_EXTENDED = 3'd2,
        ST_FOLDED   = 3'd3,
        ST_OTHER    = 3'd4
    } status_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UNFOLD_MIN = 3'd0,
        CFG_FOLD_MIN   = 3'd1,
        CFG_PULSE_MAX  = 3'd2,
        CFG_EXTENDED   = 3'd3,
        CFG_STOWED     = 3'd4,
        CFG_STALL_TO   = 3'd5
    } cfg_idx_t;

    // Configuration bundle
    typedef struct packed {
        logic [PULSE_W-1:0] unfold_pulse_min;
        logic [PULSE_W-1:0] fold_pulse_min;
        logic [PULSE_W-1:0] pulse_max;
        logic [POS_W-1:0]   extended_count;
        logic [POS_W-1:0]   stowed_count;
        logic [STALL_W-1:0] stall_timeout;
    } cfg_t;

    // One result
    typedef struct packed {
        logic [MODE_W-1:0]   motion_mode;
        logic                motor_on;
        logic                motor_unfold;
        logic [REV_W-1:0]    revolutions;
        logic [STATUS_W-1:0] status_code;
    } res_t;

endpackage

>>> rtl/core/rbpc_evt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbpc_evt_if
// Event request channel: tick, reed level change or command.
// ----------------------------------------------------------------------------
interface rbpc_evt_if;
    import rbpc_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic              reed_level;

    modport source (output valid, output func, output reed_level, input ready);
    modport sink   (input valid, input func, input reed_level, output ready);
endinterface

>>> rtl/core/rbpc_rpt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbpc_rpt_if
// Result request channel: motor drive, count and position status.
// ----------------------------------------------------------------------------
interface rbpc_rpt_if;
    import rbpc_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   motion_mode;
    logic                motor_on;
    logic                motor_unfold;
    logic [REV_W-1:0]    revolutions;
    logic [STATUS_W-1:0] status_code;

    modport source (output valid, output motion_mode, output motor_on,
                    output motor_unfold, output revolutions, output status_code,
                    input ready);
    modport sink   (input valid, input motion_mode, input motor_on,
                    input motor_unfold, input revolutions, input status_code,
                    output ready);
endinterface

>>> rtl/core/rbpc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbpc_cfg_regs
// Write-only configuration register file.
// ----------------------------------------------------------------------------
module rbpc_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [rbpc_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [rbpc_pkg::CFG_DATA_W-1:0] cfg_data,
    output rbpc_pkg::cfg_t              cfg
);
    import rbpc_pkg::*;

    cfg_t cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unfold_pulse_min <= UNFOLD_MIN_RST;
            cfg_reg.fold_pulse_min   <= FOLD_MIN_RST;
            cfg_reg.pulse_max        <= PULSE_MAX_RST;
            cfg_reg.extended_count   <= EXTENDED_RST;
            cfg_reg.stowed_count     <= STOWED_RST;
            cfg_reg.stall_timeout    <= STALL_TO_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_idx))
                CFG_UNFOLD_MIN: cfg_reg.unfold_pulse_min <= cfg_data[PULSE_W-1:0];
                CFG_FOLD_MIN:   cfg_reg.fold_pulse_min   <= cfg_data[PULSE_W-1:0];
                CFG_PULSE_MAX:  cfg_reg.pulse_max        <= cfg_data[PULSE_W-1:0];
                CFG_EXTENDED:   cfg_reg.extended_count   <= cfg_data[POS_W-1:0];
                CFG_STOWED:     cfg_reg.stowed_count     <= cfg_data[POS_W-1:0];
                CFG_STALL_TO:   cfg_reg.stall_timeout    <= cfg_data[STALL_W-1:0];
                default:        ; // unused indexes are ignored
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/rbpc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbpc_step
// Controller state and the single-pass update for one event.
// ----------------------------------------------------------------------------
module rbpc_step #(
    parameter int COUNT_WIDTH       = rbpc_pkg::COUNT_WIDTH_DEF,
    parameter int PULSE_TIMER_WIDTH = rbpc_pkg::PULSE_TIMER_WIDTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  rbpc_pkg::func_t func,
    input  logic            reed_level,
    input  rbpc_pkg::cfg_t  cfg,
    output rbpc_pkg::res_t  res
);
    import rbpc_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

    mode_t                        mode_reg, mode_next;
    logic                         dir_valid_reg, dir_valid_next;
    logic                         dir_unfold_reg, dir_unfold_next;
    logic [PULSE_TIMER_WIDTH-1:0] ptimer_reg, ptimer_next;
    logic                         started_reg, started_next;
    logic [COUNT_WIDTH-1:0]       count_reg, count_next;
    logic [COUNT_WIDTH-1:0]       mark_reg, mark_next;
    logic [STALL_W-1:0]           stall_reg, stall_next;
    logic [POS_W-1:0]             target_reg, target_next;
    status_t                      status_reg, status_next;

    logic [PULSE_W-1:0]           pulse_lo;
    logic signed [CALC_W-1:0]     count_ext;
    logic signed [CALC_W-1:0]     mark_ext;
    logic signed [CALC_W-1:0]     target_ext;
    logic signed [CALC_W-1:0]     ext_ext;
    logic signed [CALC_W-1:0]     stow_ext;
    logic signed [CALC_W-1:0]     diff;
    logic                         at_target;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            dir_valid_reg  <= 1'b0;
            dir_unfold_reg <= 1'b0;
            ptimer_reg     <= '0;
            started_reg    <= 1'b0;
            count_reg      <= '0;
            mark_reg       <= '0;
            stall_reg      <= '0;
            target_reg     <= '0;
            status_reg     <= ST_NONE;
        end
        else
        begin
            mode_reg       <= mode_next;
            dir_valid_reg  <= dir_valid_next;
            dir_unfold_reg <= dir_unfold_next;
            ptimer_reg     <= ptimer_next;
            started_reg    <= started_next;
            count_reg      <= count_next;
            mark_reg       <= mark_next;
            stall_reg      <= stall_next;
            target_reg     <= target_next;
            status_reg     <= status_next;
        end
    end

    // Event handling, then stop and stall checks on the updated state
    always_comb
    begin
        mode_next       = mode_reg;
        dir_valid_next  = dir_valid_reg;
        dir_unfold_next = dir_unfold_reg;
        ptimer_next     = ptimer_reg;
        started_next    = started_reg;
        count_next      = count_reg;
        mark_next       = mark_reg;
        stall_next      = stall_reg;
        target_next     = target_reg;
        status_next     = status_reg;

        pulse_lo = dir_unfold_reg ? cfg.unfold_pulse_min : cfg.fold_pulse_min;

        if (fire)
        begin
            unique case (func)
                FUNC_TICK:
                begin
                    if (started_reg && (ptimer_reg != '1))
                        ptimer_next = ptimer_reg + PULSE_TIMER_WIDTH'(1);
                    if ((mode_reg == MODE_MOVING) && (stall_reg != '1))
                        stall_next = stall_reg + STALL_W'(1);
                end
                FUNC_REED:
                begin
                    if (!reed_level)
                    begin
                        ptimer_next  = '0;
                        started_next = 1'b1;
                    end
                    else if (started_reg && dir_valid_reg
                             && (PT_CMP_W'(ptimer_reg) >= PT_CMP_W'(pulse_lo))
                             && (PT_CMP_W'(ptimer_reg) < PT_CMP_W'(cfg.pulse_max)))
                    begin
                        // count one revolution, saturating
                        if (dir_unfold_reg)
                        begin
                            if (count_reg != CNT_MAX)
                                count_next = count_reg + COUNT_WIDTH'(1);
                        end
                        else if (count_reg != CNT_MIN)
                        begin
                            count_next = count_reg - COUNT_WIDTH'(1);
                        end
                    end
                end
                FUNC_FOLD, FUNC_UNFOLD:
                begin
                    mode_next       = MODE_MOVING;
                    dir_valid_next  = 1'b1;
                    dir_unfold_next = (func == FUNC_UNFOLD);
                    target_next     = (func == FUNC_UNFOLD) ? cfg.extended_count
                                                            : cfg.stowed_count;
                    stall_next      = '0;
                    mark_next       = count_reg;
                    started_next    = 1'b0;
                    ptimer_next     = '0;
                    status_next     = ST_MOVING;
                end
                default: ;
            endcase
        end

        // Signed views for position math
        count_ext  = CALC_W'($signed(count_next));
        mark_ext   = CALC_W'($signed(mark_next));
        target_ext = CALC_W'($signed(target_next));
        ext_ext    = CALC_W'($signed(cfg.extended_count));
        stow_ext   = CALC_W'($signed(cfg.stowed_count));
        diff       = count_ext - mark_ext;
        at_target  = dir_unfold_next ? (count_ext >= target_ext)
                                     : (count_ext <= target_ext);

        if (fire && (mode_next == MODE_MOVING))
        begin
            // target reached or passed
            if (at_target)
            begin
                mode_next = MODE_IDLE;
                if (count_ext == ext_ext)
                    status_next = ST_EXTENDED;
                else if (count_ext == stow_ext)
                    status_next = ST_FOLDED;
                else
                    status_next = ST_OTHER;
            end
            // watchdog wins over a stop in the same event
            if (stall_next > cfg.stall_timeout)
                mode_next = MODE_ERROR;
            // two revolutions of progress restart the watchdog
            if ((diff > CALC_W'(1)) || (diff < -CALC_W'(1)))
            begin
                stall_next = '0;
                mark_next  = count_next;
            end
        end

        res.motion_mode  = mode_next;
        res.motor_on     = (mode_next == MODE_MOVING);
        res.motor_unfold = dir_valid_next & dir_unfold_next;
        res.revolutions  = count_ext[REV_W-1:0];
        res.status_code  = status_next;
    end

endmodule

>>> rtl/core/roller_blind_position_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roller_blind_position_controller
// Counts reed switch revolutions, drives the blind motor toward the fold or
// unfold target and latches a stall error.
// ----------------------------------------------------------------------------
// Every request on evt (a millisecond tick, a reed level change, or a fold or
// unfold command) yields exactly one result on rpt, in order. A request is
// registered on entry, applied to the controller state through the single
// state-update path, and its result is registered for output; a new request
// is taken every cycle while rpt keeps up. Revolutions are counted in
// COUNT_WIDTH bits and reported in 10 bits; the pulse timer is
// PULSE_TIMER_WIDTH bits. No clearing pass is needed after reset.
// Configuration is written through cfg_we/cfg_idx/cfg_data; the user must
// do so only while no request is in flight, which the block does not enforce.
// ----------------------------------------------------------------------------
module roller_blind_position_controller #(
    parameter int COUNT_WIDTH       = rbpc_pkg::COUNT_WIDTH_DEF,
    parameter int PULSE_TIMER_WIDTH = rbpc_pkg::PULSE_TIMER_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    rbpc_evt_if.sink                        evt,
    rbpc_rpt_if.source                      rpt,
    input  logic                            cfg_we,
    input  logic [rbpc_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [rbpc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rbpc_pkg::*;

    cfg_t  cfg;
    res_t  res;
    res_t  res_reg;
    func_t func_reg;
    logic  reed_reg;
    logic  in_valid_reg;
    logic  out_valid_reg;
    logic  fire;

    // Configuration registers
    rbpc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    // Controller state and update
    rbpc_step #(
        .COUNT_WIDTH       (COUNT_WIDTH),
        .PULSE_TIMER_WIDTH (PULSE_TIMER_WIDTH)
    ) u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .func       (func_reg),
        .reed_level (reed_reg),
        .cfg        (cfg),
        .res        (res)
    );

    // Process the held request when the result slot is free or draining
    assign fire      = in_valid_reg && (!out_valid_reg || rpt.ready);
    assign evt.ready = !in_valid_reg || fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (evt.valid && evt.ready)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
        begin
            func_reg <= func_t'(evt.func);
            reed_reg <= evt.reed_level;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (rpt.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= res;
    end

    assign rpt.valid        = out_valid_reg;
    assign rpt.motion_mode  = res_reg.motion_mode;
    assign rpt.motor_on     = res_reg.motor_on;
    assign rpt.motor_unfold = res_reg.motor_unfold;
    assign rpt.revolutions  = res_reg.revolutions;
    assign rpt.status_code  = res_reg.status_code;

endmodule

>>> verif/roller_blind_position_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roller_blind_position_controller_tb
// Self-checking bench for the roller blind position controller.
// ----------------------------------------------------------------------------
// Drives ticks, reed edges and fold/unfold commands on the event channel and
// checks every report against a cycle-free model of the controller. A short
// scripted run covers the opening behavior. Randomized phases follow, built
// mostly from reed pulses around the qualifying window, tick bursts and
// commands, each under its own register setting. The last phase drives the
// revolution count into saturation. Both channel ends idle at random, and
// once the report side holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module roller_blind_position_controller_tb;
    import rbpc_pkg::*;

    localparam int REV_MAX = (1 << (COUNT_WIDTH_DEF - 1)) - 1;
    localparam int REV_MIN = -(1 << (COUNT_WIDTH_DEF - 1));
    localparam int PULSE_MS_MAX = (1 << PULSE_TIMER_WIDTH_DEF) - 1;
    localparam int STALL_MS_MAX = 65535;

    // Fixed reports that need no model
    localparam res_t AT_REST = '{MODE_IDLE, 1'b0, 1'b0, 10'd0, ST_NONE};
    localparam res_t UNFOLD_START = '{MODE_MOVING, 1'b1, 1'b1, 10'd0, ST_MOVING};

    typedef struct packed {
        func_t f;
        logic  lvl;
        logic  typed;
        res_t  rpt;
    } script_row_t;

    typedef struct packed {
        logic typed;
        res_t rpt;
    } req_note_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    rbpc_evt_if evt ();
    rbpc_rpt_if rpt ();

    roller_blind_position_controller uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .evt      (evt),
        .rpt      (rpt),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    // Model state of the blind controller
    mode_t   blind_mode;
    int      blind_dir;
    int      pulse_ms;
    bit      pulse_armed;
    int      blind_revs;
    int      progress_mark;
    int      stall_ms;
    int      goal_revs;
    status_t blind_status;

    // Model copy of the registers
    int unfold_min_ms;
    int fold_min_ms;
    int pulse_max_ms;
    int extended_revs;
    int stowed_revs;
    int stall_limit_ms;

    req_note_t req_notes [$];
    res_t      due_reports [$];

    int mismatches;
    int sent_count;
    int send_gap_pct;
    int recv_stall_pct;
    bit hold_req;

    // Scripted opening: unfold pulses of 2 ms, fold 1..2 ms, targets 2 / -1,
    // watchdog beyond 4 ms
    script_row_t script [24] = '{
        '{FUNC_TICK,   1'b0, 1'b1, AT_REST},       // state after reset
        '{FUNC_REED,   1'b1, 1'b1, AT_REST},       // high edge, no low edge yet
        '{FUNC_REED,   1'b0, 1'b1, AT_REST},
        '{FUNC_TICK,   1'b0, 1'b1, AT_REST},
        '{FUNC_REED,   1'b1, 1'b1, AT_REST},       // pulse before any command
        '{FUNC_UNFOLD, 1'b0, 1'b1, UNFOLD_START},
        '{FUNC_REED,   1'b1, 1'b1, UNFOLD_START},  // no low edge since command
        '{FUNC_REED,   1'b0, 1'b0, '0},
        '{FUNC_TICK,   1'b1, 1'b0, '0},
        '{FUNC_TICK,   1'b0, 1'b0, '0},
        '{FUNC_REED,   1'b1, 1'b0, '0},            // counts one
        '{FUNC_REED,   1'b1, 1'b0, '0},            // repeated high edge, reaches target
        '{FUNC_REED,   1'b0, 1'b0, '0},
        '{FUNC_TICK,   1'b0, 1'b0, '0},
        '{FUNC_TICK,   1'b1, 1'b0, '0},
        '{FUNC_REED,   1'b1, 1'b0, '0},            // counts while idle
        '{FUNC_FOLD,   1'b1, 1'b0, '0},
        '{FUNC_UNFOLD, 1'b1, 1'b0, '0},            // restart while moving, stops at once
        '{FUNC_FOLD,   1'b0, 1'b0, '0},
        '{FUNC_TICK,   1'b0, 1'b0, '0},
        '{FUNC_TICK,   1'b1, 1'b0, '0},
        '{FUNC_TICK,   1'b0, 1'b0, '0},
        '{FUNC_TICK,   1'b1, 1'b0, '0},
        '{FUNC_TICK,   1'b0, 1'b0, '0}             // watchdog fires, no stop
    };

    // Apply one event to the model and return its report
    function automatic res_t advance_blind(input func_t f, input logic lvl);
        int   lo_ms;
        int   next_revs;
        int   drift;
        res_t r;
        case (f)
            FUNC_TICK:
            begin
                if (pulse_armed && pulse_ms < PULSE_MS_MAX) pulse_ms++;
                if (blind_mode == MODE_MOVING && stall_ms < STALL_MS_MAX) stall_ms++;
            end
            FUNC_REED:
            begin
                if (!lvl)
                begin
                    pulse_ms = 0;
                    pulse_armed = 1'b1;
                end
                else
                begin
                    lo_ms = (blind_dir > 0) ? unfold_min_ms : fold_min_ms;
                    if (pulse_armed && pulse_ms >= lo_ms && pulse_ms < pulse_max_ms)
                    begin
                        next_revs = blind_revs + blind_dir;
                        if (next_revs > REV_MAX) next_revs = REV_MAX;
                        if (next_revs < REV_MIN) next_revs = REV_MIN;
                        blind_revs = next_revs;
                    end
                end
            end
            default:
            begin
                blind_mode = MODE_MOVING;
                blind_dir = (f == FUNC_UNFOLD) ? 1 : -1;
                goal_revs = (f == FUNC_UNFOLD) ? extended_revs : stowed_revs;
                stall_ms = 0;
                progress_mark = blind_revs;
                pulse_armed = 1'b0;
                pulse_ms = 0;
                blind_status = ST_MOVING;
            end
        endcase

        // Stop and stall tests; a stall wins over a stop in the same event
        if (blind_mode == MODE_MOVING)
        begin
            if (blind_dir * (blind_revs - goal_revs) >= 0)
            begin
                blind_mode = MODE_IDLE;
                if (blind_revs == extended_revs) blind_status = ST_EXTENDED;
                else if (blind_revs == stowed_revs) blind_status = ST_FOLDED;
                else blind_status = ST_OTHER;
            end
            if (stall_ms > stall_limit_ms) blind_mode = MODE_ERROR;
            drift = blind_revs - progress_mark;
            if (drift > 1 || drift < -1)
            begin
                stall_ms = 0;
                progress_mark = blind_revs;
            end
        end

        r.motion_mode = blind_mode;
        r.motor_on = (blind_mode == MODE_MOVING);
        r.motor_unfold = (blind_dir > 0);
        r.revolutions = blind_revs[REV_W-1:0];
        r.status_code = blind_status;
        return r;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Present one request and hold it until taken
    task automatic send_request(input func_t f, input logic lvl, input logic typed,
                                input res_t rpt_fixed);
        while ($urandom_range(99) < send_gap_pct)
        begin
            evt.valid <= 1'b0;
            @(posedge clk);
        end
        req_notes.push_back('{typed, rpt_fixed});
        evt.valid <= 1'b1;
        evt.func <= f;
        evt.reed_level <= lvl;
        @(posedge clk);
        while (!evt.ready) @(posedge clk);
        sent_count++;
    endtask

    task automatic send_event(input func_t f, input logic lvl);
        send_request(f, lvl, 1'b0, '0);
    endtask

    // One reed pulse of len_ms ticks, now and then with a repeated high edge
    task automatic send_pulse(input int len_ms);
        send_event(FUNC_REED, 1'b0);
        repeat (len_ms) send_event(FUNC_TICK, 1'($urandom_range(1)));
        send_event(FUNC_REED, 1'b1);
        if ($urandom_range(99) < 15) send_event(FUNC_REED, 1'b1);
    endtask

    // Wait until every report is back and the pipeline is empty
    task automatic wait_quiet();
        evt.valid <= 1'b0;
        while (req_notes.size() != 0 || due_reports.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_settings(input cfg_t c);
        logic [CFG_DATA_W-1:0] vals [6];
        cfg_idx_t              slots [6];
        wait_quiet();
        slots = '{CFG_UNFOLD_MIN, CFG_FOLD_MIN, CFG_PULSE_MAX,
                  CFG_EXTENDED, CFG_STOWED, CFG_STALL_TO};
        vals = '{16'(c.unfold_pulse_min), 16'(c.fold_pulse_min), 16'(c.pulse_max),
                 16'($signed(c.extended_count)), 16'($signed(c.stowed_count)),
                 c.stall_timeout};
        for (int i = 0; i < 6; i++)
        begin
            cfg_we <= 1'b1;
            cfg_idx <= slots[i];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        unfold_min_ms = c.unfold_pulse_min;
        fold_min_ms = c.fold_pulse_min;
        pulse_max_ms = c.pulse_max;
        extended_revs = int'($signed(c.extended_count));
        stowed_revs = int'($signed(c.stowed_count));
        stall_limit_ms = c.stall_timeout;
        @(posedge clk);
    endtask

    // Random traffic: mostly pulses near the window, plus commands, ticks and noise
    task automatic run_random_phase(input int n_items);
        int first;
        int pick;
        int lo_ms;
        int len_ms;
        first = sent_count;
        lo_ms = (unfold_min_ms > fold_min_ms) ? unfold_min_ms : fold_min_ms;
        while (sent_count - first < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                send_event($urandom_range(1) ? FUNC_UNFOLD : FUNC_FOLD, 1'($urandom_range(1)));
            else if (pick < 75)
            begin
                if ($urandom_range(9) < 7 && lo_ms < pulse_max_ms)
                    len_ms = $urandom_range(lo_ms, (pulse_max_ms - 1 < lo_ms + 8) ?
                                                   pulse_max_ms - 1 : lo_ms + 8);
                else
                    len_ms = $urandom_range(0, (pulse_max_ms + 3 < 30) ? pulse_max_ms + 3 : 30);
                send_pulse(len_ms);
            end
            else if (pick < 90)
            begin
                // tick burst, sometimes long enough to trip the watchdog
                if ($urandom_range(3) == 0 && stall_limit_ms <= 80)
                    repeat (stall_limit_ms + 2) send_event(FUNC_TICK, 1'($urandom_range(1)));
                else
                    repeat ($urandom_range(6, 1)) send_event(FUNC_TICK, 1'($urandom_range(1)));
            end
            else
                send_event(func_t'($urandom_range(3)), 1'($urandom_range(1)));
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Report side ready, with random stalls and one long hold-off on request
    initial
    begin : report_ready
        int hold_left;
        hold_left = 0;
        rpt.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rpt.ready <= 1'b0;
            end
            else
                rpt.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Model the accepted requests and check the reports, in one place per edge
    always @(posedge clk)
    begin : report_check
        req_note_t note;
        res_t      want;
        if (rst_n)
        begin
            if (evt.valid && evt.ready)
            begin
                note = req_notes.pop_front();
                want = advance_blind(func_t'(evt.func), evt.reed_level);
                if (note.typed) want = note.rpt;
                due_reports.push_back(want);
            end
            if (rpt.valid && rpt.ready)
            begin
                if (due_reports.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: report with none expected, actual mode %0d rev %0d st %0d",
                             $time, rpt.motion_mode, $signed(rpt.revolutions), rpt.status_code);
                end
                else
                begin
                    want = due_reports.pop_front();
                    compare_field("motion_mode", want.motion_mode, rpt.motion_mode);
                    compare_field("motor_on", want.motor_on, rpt.motor_on);
                    compare_field("motor_unfold", want.motor_unfold, rpt.motor_unfold);
                    compare_field("revolutions", int'($signed(want.revolutions)),
                                  int'($signed(rpt.revolutions)));
                    compare_field("status_code", want.status_code, rpt.status_code);
                end
            end
        end
    end

    // Stimulus sequence
    initial
    begin : stimulus
        cfg_t plan [9];
        int   items_per_phase [9];
        int   gap_plan [9];
        int   stall_plan [9];
        int   reach;

        rst_n = 1'b0;
        evt.valid = 1'b0;
        evt.func = FUNC_TICK;
        evt.reed_level = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_UNFOLD_MIN;
        cfg_data = '0;
        hold_req = 1'b0;
        mismatches = 0;
        sent_count = 0;
        send_gap_pct = 18;
        recv_stall_pct = 83;

        // Model reset
        blind_mode = MODE_IDLE;
        blind_dir = 0;
        pulse_ms = 0;
        pulse_armed = 1'b0;
        blind_revs = 0;
        progress_mark = 0;
        stall_ms = 0;
        goal_revs = 0;
        blind_status = ST_NONE;
        unfold_min_ms = UNFOLD_MIN_RST;
        fold_min_ms = FOLD_MIN_RST;
        pulse_max_ms = PULSE_MAX_RST;
        extended_revs = int'($signed(EXTENDED_RST));
        stowed_revs = int'($signed(STOWED_RST));
        stall_limit_ms = STALL_TO_RST;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Scripted opening
        load_settings('{10'd2, 10'd1, 10'd3, 10'd2, -10'sd1, 16'd4});
        foreach (script[i])
            send_request(script[i].f, script[i].lvl, script[i].typed, script[i].rpt);

        plan[0] = '{10'd3, 10'd2, 10'd6, 10'd6, -10'sd4, 16'd40};
        plan[1] = '{10'd1, 10'd1, 10'd1023, 10'd511, -10'sd512, 16'd1};
        plan[2] = '{10'd1023, 10'd1023, 10'd1023, 10'd3, -10'sd3, 16'd65535};
        plan[3] = '{10'd5, 10'd4, 10'd9, 10'd0, 10'd0, 16'd20};
        plan[4] = '{10'd2, 10'd3, 10'd2, 10'd4, -10'sd2, 16'd8};
        plan[7] = '{10'd4, 10'd6, 10'd12, -10'sd5, 10'd5, 16'd30};
        plan[8] = '{10'd1, 10'd1, 10'd4, 10'd511, -10'sd512, 16'd65535};
        items_per_phase = '{40, 40, 30, 40, 30, 40, 60, 40, 0};
        gap_plan = '{18, 18, 18, 83, 83, 83, 0, 0, 0};
        stall_plan = '{83, 83, 83, 18, 18, 18, 0, 0, 0};

        for (int p = 0; p < 9; p++)
        begin
            if (p == 5 || p == 6)
                plan[p] = '{10'($urandom_range(8, 1)), 10'($urandom_range(8, 1)),
                            10'($urandom_range(14, 1)), 10'(int'($urandom_range(12)) - 6),
                            10'(int'($urandom_range(12)) - 6), 16'($urandom_range(60, 2))};
            load_settings(plan[p]);
            send_gap_pct = gap_plan[p];
            recv_stall_pct = stall_plan[p];
            if (p == 6) hold_req = 1'b1;
            if (p == 8)
            begin
                // run the count up past the top of its range; after one
                // qualifying low edge every repeated high edge counts again
                reach = REV_MAX - blind_revs + 6;
                send_event(FUNC_UNFOLD, 1'b0);
                send_event(FUNC_REED, 1'b0);
                send_event(FUNC_TICK, 1'b0);
                repeat (reach) send_event(FUNC_REED, 1'b1);
            end
            else
                run_random_phase(items_per_phase[p]);
            // a pulse long enough to pin the pulse timer at all ones
            if (p == 1) send_pulse(PULSE_MS_MAX + 7);
        end

        wait_quiet();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Timeout guard
    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
